FILE: design/tlb_lru_page_translation_macros.svh
`ifndef TLB_LRU_PAGE_TRANSLATION_MACROS_SVH
`define TLB_LRU_PAGE_TRANSLATION_MACROS_SVH

// same-cycle implication, held off during reset
`define TLB_LRU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define TLB_LRU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/tlb_lru_pkg.sv
package tlb_lru_pkg;

  localparam int unsigned ADDR_W          = 16;
  localparam int unsigned PAGE_W          = 8;
  localparam int unsigned OFFSET_W        = 8;
  localparam int unsigned FRAME_W         = 8;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned PAGE_COUNT      = 256;
  localparam int unsigned FREE_W          = 9;
  localparam int unsigned TLB_ENTRIES_DEF = 16;

  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } ptab_rsp_t;

  typedef struct packed {
    logic   hit;
    logic   full;
    frame_t frame;
  } cam_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_INSTALL,
    ST_FINISH
  } state_e;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: design/tlb_lru_page_translation.sv
// On a TLB hit or a miss with a free slot, a result passes ST_LOOKUP and ST_FINISH into the
// output register behind out_valid_o; on a miss with a full TLB, ST_SCAN (LRU scan, one
// stamp per cycle) and ST_INSTALL lie between. One address in flight: the next one is taken
// only back in ST_IDLE, later while the output beat is held off by out_ready_i.
// Reset clears TLB and page-table present bits, counts and the free-frame
// pointer at once; no clearing pass.
module tlb_lru_page_translation import tlb_lru_pkg::*; #(
  parameter int unsigned TLB_ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ADDR_W-1:0] logical_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ADDR_W-1:0] physical_address_o,
  output logic              tlb_hit_o,
  output logic              page_fault_o,
  output logic [CNT_W-1:0]  reference_total_o,
  output logic [CNT_W-1:0]  hit_total_o,
  output logic [CNT_W-1:0]  fault_total_o
);

`include "tlb_lru_page_translation_macros.svh"

  localparam int unsigned IW = $clog2(TLB_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TLB_ENTRIES - 1);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] addr_q;
  cnt_t              ref_cnt_q, hit_cnt_q, fault_cnt_q;
  logic [FREE_W-1:0] free_next_q;
  frame_t            frame_q;
  logic              hit_q, fault_q;
  logic [IW-1:0]     slot_q, scan_idx_q;
  cnt_t              best_q;

  logic              out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic              out_hit_q, out_fault_q;
  cnt_t              out_ref_q, out_hits_q, out_faults_q;

  logic      in_accept, out_load;
  page_t     page_q;
  ptab_rsp_t ptab_rsp;
  logic      ptab_we;
  cam_rsp_t  cam_rsp;
  logic [IW-1:0] cam_hit_idx, cam_free_idx;
  logic      cam_we;
  logic [IW-1:0] cam_widx;
  frame_t    cam_wframe;
  logic      stamp_we, stamp_re;
  logic [IW-1:0] stamp_waddr, stamp_raddr;
  cnt_t      stamp_rdata;
  frame_t    lk_frame;
  logic      lk_fault;

  assign page_q    = addr_q[ADDR_W-1 -: PAGE_W];
  assign in_accept = in_valid_i && in_ready_o;
  assign lk_fault  = !cam_rsp.hit && !ptab_rsp.valid;
  assign lk_frame  = cam_rsp.hit    ? cam_rsp.frame  :
                     ptab_rsp.valid ? ptab_rsp.frame : free_next_q[FRAME_W-1:0];

  tlb_lru_ptab u_ptab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_page_i  (logical_address_i[ADDR_W-1 -: PAGE_W]),
    .wr_en_i    (ptab_we),
    .wr_page_i  (page_q),
    .wr_frame_i (free_next_q[FRAME_W-1:0]),
    .rsp_o      (ptab_rsp)
  );

  tlb_lru_cam #(
    .ENTRIES (TLB_ENTRIES)
  ) u_cam (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .page_i     (page_q),
    .we_i       (cam_we),
    .widx_i     (cam_widx),
    .wpage_i    (page_q),
    .wframe_i   (cam_wframe),
    .rsp_o      (cam_rsp),
    .hit_idx_o  (cam_hit_idx),
    .free_idx_o (cam_free_idx)
  );

  tlb_lru_ram #(
    .WIDTH (CNT_W),
    .DEPTH (TLB_ENTRIES)
  ) u_stamp_ram (
    .clk_i     (clk_i),
    .wr_en_i   (stamp_we),
    .wr_addr_i (stamp_waddr),
    .wr_data_i (ref_cnt_q),
    .rd_en_i   (stamp_re),
    .rd_addr_i (stamp_raddr),
    .rd_data_o (stamp_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = (!cam_rsp.hit && cam_rsp.full) ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (scan_idx_q == LAST_IDX) state_d = ST_INSTALL;
      end
      ST_INSTALL: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o  = 1'b0;
    ptab_we     = 1'b0;
    cam_we      = 1'b0;
    cam_widx    = cam_free_idx;
    cam_wframe  = lk_frame;
    stamp_we    = 1'b0;
    stamp_waddr = cam_free_idx;
    stamp_re    = 1'b0;
    stamp_raddr = '0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      ST_LOOKUP: begin
        if (cam_rsp.hit) begin
          stamp_we    = 1'b1;
          stamp_waddr = cam_hit_idx;
        end else begin
          ptab_we = lk_fault;
          if (!cam_rsp.full) begin
            cam_we   = 1'b1;
            stamp_we = 1'b1;
          end else begin
            stamp_re = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        stamp_re    = (scan_idx_q != LAST_IDX);
        stamp_raddr = scan_idx_q + IW'(1);
      end
      ST_INSTALL: begin
        cam_we      = 1'b1;
        cam_widx    = slot_q;
        cam_wframe  = frame_q;
        stamp_we    = 1'b1;
        stamp_waddr = slot_q;
      end
      ST_FINISH: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ref_cnt_q   <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
      free_next_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        ref_cnt_q <= sat_inc(ref_cnt_q);
      end
      if (state_q == ST_LOOKUP) begin
        if (cam_rsp.hit) begin
          hit_cnt_q <= sat_inc(hit_cnt_q);
        end else if (lk_fault) begin
          fault_cnt_q <= sat_inc(fault_cnt_q);
          if (free_next_q < FREE_W'(PAGE_COUNT)) begin
            free_next_q <= free_next_q + FREE_W'(1);
          end
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      addr_q <= logical_address_i;
    end
    if (state_q == ST_LOOKUP) begin
      frame_q    <= lk_frame;
      hit_q      <= cam_rsp.hit;
      fault_q    <= lk_fault;
      scan_idx_q <= '0;
    end
    // stamp for scan_idx_q lands this cycle; strict less keeps lowest slot on ties
    if (state_q == ST_SCAN) begin
      if ((scan_idx_q == '0) || (stamp_rdata < best_q)) begin
        best_q <= stamp_rdata;
        slot_q <= scan_idx_q;
      end
      scan_idx_q <= scan_idx_q + IW'(1);
    end
    if (out_load) begin
      out_addr_q   <= {frame_q, addr_q[OFFSET_W-1:0]};
      out_hit_q    <= hit_q;
      out_fault_q  <= fault_q;
      out_ref_q    <= ref_cnt_q;
      out_hits_q   <= hit_cnt_q;
      out_faults_q <= fault_cnt_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign physical_address_o = out_addr_q;
  assign tlb_hit_o          = out_hit_q;
  assign page_fault_o       = out_fault_q;
  assign reference_total_o  = out_ref_q;
  assign hit_total_o        = out_hits_q;
  assign fault_total_o      = out_faults_q;

  `TLB_LRU_ASSERT_IMP(a_install_no_dup, cam_we, !cam_rsp.hit, "TLB install of a page already held")
  `TLB_LRU_ASSERT_IMP(a_hits_le_refs, 1'b1, hit_cnt_q <= ref_cnt_q, "hit count above reference count")
  `TLB_LRU_ASSERT_IMP(a_faults_le_refs, 1'b1, fault_cnt_q <= ref_cnt_q, "fault count above reference count")
  `TLB_LRU_ASSERT_IMP(a_hit_xor_fault, out_valid_o, !(tlb_hit_o && page_fault_o), "hit and fault in one beat")
  `TLB_LRU_ASSERT_NEXT(a_load_shows, out_load, out_valid_q, "loaded result not presented")

endmodule

FILE: design/tlb_lru_ram.sv
module tlb_lru_ram import tlb_lru_pkg::*; #(
  parameter int unsigned WIDTH = CNT_W,
  parameter int unsigned DEPTH = TLB_ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/tlb_lru_ptab.sv
module tlb_lru_ptab import tlb_lru_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      rd_en_i,
  input  page_t     rd_page_i,
  input  logic      wr_en_i,
  input  page_t     wr_page_i,
  input  frame_t    wr_frame_i,
  output ptab_rsp_t rsp_o
);

  // present bits in flops, cleared at once by reset; frames only in the RAM
  logic [PAGE_COUNT-1:0] valid_q;
  logic                  valid_rd_q;
  frame_t                frame_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      valid_rd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_page_i] <= 1'b1;
      end
      if (rd_en_i) begin
        valid_rd_q <= valid_q[rd_page_i];
      end
    end
  end

  tlb_lru_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGE_COUNT)
  ) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_page_i),
    .wr_data_i (wr_frame_i),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_page_i),
    .rd_data_o (frame_rd)
  );

  assign rsp_o.valid = valid_rd_q;
  assign rsp_o.frame = frame_rd;

endmodule

FILE: design/tlb_lru_cam.sv
module tlb_lru_cam import tlb_lru_pkg::*; #(
  parameter int unsigned ENTRIES = TLB_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  page_t                      page_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] widx_i,
  input  page_t                      wpage_i,
  input  frame_t                     wframe_i,
  output cam_rsp_t                   rsp_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic [$clog2(ENTRIES)-1:0] free_idx_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [ENTRIES-1:0] valid_q;
  page_t              page_q  [ENTRIES];
  frame_t             frame_q [ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[widx_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      page_q[widx_i]  <= wpage_i;
      frame_q[widx_i] <= wframe_i;
    end
  end

  // walk downwards so the lowest matching / free slot wins
  always_comb begin
    rsp_o.hit   = 1'b0;
    rsp_o.frame = '0;
    hit_idx_o   = '0;
    free_idx_o  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (page_q[i] == page_i)) begin
        rsp_o.hit   = 1'b1;
        rsp_o.frame = frame_q[i];
        hit_idx_o   = IW'(i);
      end
      if (!valid_q[i]) begin
        free_idx_o = IW'(i);
      end
    end
    rsp_o.full = &valid_q;
  end

endmodule

FILE: sim/tlb_lru_page_translation_tb.sv
`timescale 1ns / 1ps

module tlb_lru_page_translation_tb;
  import tlb_lru_pkg::*;

  localparam int unsigned TLB_N       = TLB_ENTRIES_DEF;
  localparam int unsigned ADDR_BEATS  = 1650;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYC  = 2 * (TLB_N + 4);

  typedef struct packed {
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              page_fault;
    cnt_t              reference_total;
    cnt_t              hit_total;
    cnt_t              fault_total;
  } xlat_t;

  // drain marks a point where the sender holds off until all results are back
  typedef struct {
    bit                drain;
    logic [ADDR_W-1:0] addr;
  } addr_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ADDR_W-1:0] logical_address_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ADDR_W-1:0] physical_address_o;
  logic              tlb_hit_o;
  logic              page_fault_o;
  logic [CNT_W-1:0]  reference_total_o;
  logic [CNT_W-1:0]  hit_total_o;
  logic [CNT_W-1:0]  fault_total_o;

  tlb_lru_page_translation #(
    .TLB_ENTRIES(TLB_N)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .logical_address_i (logical_address_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .physical_address_o(physical_address_o),
    .tlb_hit_o         (tlb_hit_o),
    .page_fault_o      (page_fault_o),
    .reference_total_o (reference_total_o),
    .hit_total_o       (hit_total_o),
    .fault_total_o     (fault_total_o)
  );

  // shadow translation state
  bit               tlb_vld   [TLB_N];
  page_t            tlb_pg    [TLB_N];
  frame_t           tlb_frm   [TLB_N];
  cnt_t             tlb_stamp [TLB_N];
  bit               pt_vld    [PAGE_COUNT];
  frame_t           pt_frm    [PAGE_COUNT];
  logic [FREE_W-1:0] next_free;
  cnt_t             ref_cnt;
  cnt_t             hit_cnt;
  cnt_t             flt_cnt;

  addr_beat_t addr_q[$];
  xlat_t      pending_xlat_q[$];
  logic       in_fire;
  int         in_gap;
  int         in_calm;
  int         out_stall;
  int         out_calm;
  int         mismatch_cnt;
  int unsigned cycle_cnt;

  always #4 clk_i = ~clk_i;

  function automatic cnt_t bump_count(cnt_t v);
    return (v == '1) ? v : v + 1;
  endfunction

  function automatic xlat_t translate_address(logic [ADDR_W-1:0] addr);
    xlat_t  r;
    page_t  pg;
    frame_t frm;
    int     slot;
    bit     hit;
    bit     fault;
    pg    = addr[ADDR_W-1 -: PAGE_W];
    frm   = '0;
    slot  = -1;
    hit   = 1'b0;
    fault = 1'b0;
    ref_cnt = bump_count(ref_cnt);
    for (int i = 0; i < TLB_N; i++) begin
      if (slot < 0 && tlb_vld[i] && tlb_pg[i] == pg) slot = i;
    end
    if (slot >= 0) begin
      hit = 1'b1;
      frm = tlb_frm[slot];
      tlb_stamp[slot] = ref_cnt;
      hit_cnt = bump_count(hit_cnt);
    end else begin
      if (pt_vld[pg]) begin
        frm = pt_frm[pg];
      end else begin
        fault   = 1'b1;
        flt_cnt = bump_count(flt_cnt);
        frm     = next_free[FRAME_W-1:0];
        if (next_free < PAGE_COUNT) next_free = next_free + FREE_W'(1);
        pt_vld[pg] = 1'b1;
        pt_frm[pg] = frm;
      end
      // lowest free slot, else oldest stamp with lowest index on ties
      for (int i = 0; i < TLB_N; i++) begin
        if (slot < 0 && !tlb_vld[i]) slot = i;
      end
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < TLB_N; i++) begin
          if (tlb_stamp[i] < tlb_stamp[slot]) slot = i;
        end
      end
      tlb_vld[slot]   = 1'b1;
      tlb_pg[slot]    = pg;
      tlb_frm[slot]   = frm;
      tlb_stamp[slot] = ref_cnt;
    end
    r.physical_address = {frm, addr[OFFSET_W-1:0]};
    r.tlb_hit          = hit;
    r.page_fault       = fault;
    r.reference_total  = ref_cnt;
    r.hit_total        = hit_cnt;
    r.fault_total      = flt_cnt;
    return r;
  endfunction

  function automatic int draw_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_addr(logic [ADDR_W-1:0] a);
    addr_beat_t b;
    b.drain = 1'b0;
    b.addr  = a;
    addr_q.push_back(b);
  endtask

  task automatic push_drain();
    addr_beat_t b;
    b.drain = 1'b1;
    b.addr  = '0;
    addr_q.push_back(b);
  endtask

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %s: got 0x%08h, expected 0x%08h", field, got, want);
  endtask

  // sender: payload moves on the falling edge, held until the beat is taken
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (addr_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (addr_q[0].drain) begin
        in_valid_i <= 1'b0;
        if (pending_xlat_q.size() == 0) void'(addr_q.pop_front());
      end else begin
        logical_address_i <= addr_q[0].addr;
        in_valid_i        <= 1'b1;
        void'(addr_q.pop_front());
        if (in_calm != 0) begin
          in_calm <= in_calm - 1;
          in_gap  <= 0;
        end else begin
          in_gap <= draw_idle();
          if ($urandom_range(0, 99) == 0) in_calm <= $urandom_range(20, 60);
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall != 0) begin
        out_ready_i <= 1'b0;
        out_stall   <= out_stall - 1;
      end else begin
        out_ready_i <= 1'b1;
        if (out_calm != 0) out_calm <= out_calm - 1;
        else if ($urandom_range(0, 3) == 0) out_stall <= draw_idle();
        else if ($urandom_range(0, 199) == 0) out_calm <= $urandom_range(50, 200);
      end
    end
  end

  // result check before prediction so a same-edge input never jumps the queue
  always @(posedge clk_i) begin
    xlat_t want;
    in_fire   <= rst_ni && in_valid_i && in_ready_o;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_xlat_q.size() == 0) begin
          flag_mismatch("unexpected beat", 32'(physical_address_o), '0);
        end else begin
          want = pending_xlat_q.pop_front();
          if (physical_address_o !== want.physical_address)
            flag_mismatch("physical_address", 32'(physical_address_o),
                          32'(want.physical_address));
          if (tlb_hit_o !== want.tlb_hit)
            flag_mismatch("tlb_hit", 32'(tlb_hit_o), 32'(want.tlb_hit));
          if (page_fault_o !== want.page_fault)
            flag_mismatch("page_fault", 32'(page_fault_o), 32'(want.page_fault));
          if (reference_total_o !== want.reference_total)
            flag_mismatch("reference_total", reference_total_o, want.reference_total);
          if (hit_total_o !== want.hit_total)
            flag_mismatch("hit_total", hit_total_o, want.hit_total);
          if (fault_total_o !== want.fault_total)
            flag_mismatch("fault_total", fault_total_o, want.fault_total);
        end
      end
      if (in_valid_i && in_ready_o)
        pending_xlat_q.push_back(translate_address(logical_address_i));
    end
  end

  initial begin
    int    perm [PAGE_COUNT];
    int    ws   [$];
    int    n;
    int    mode;
    int    run;
    int    k;
    int    j;
    int    tmp;
    int    pg;
    bit    swept;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    logical_address_i = '0;
    out_ready_i       = 1'b0;
    in_fire           = 1'b0;
    in_gap            = 0;
    in_calm           = 0;
    out_stall         = 0;
    out_calm          = 0;
    mismatch_cnt      = 0;
    cycle_cnt         = 0;
    next_free         = '0;
    ref_cnt           = '0;
    hit_cnt           = '0;
    flt_cnt           = '0;
    for (int i = 0; i < TLB_N; i++) begin
      tlb_vld[i]   = 1'b0;
      tlb_pg[i]    = '0;
      tlb_frm[i]   = '0;
      tlb_stamp[i] = '0;
    end
    for (int i = 0; i < PAGE_COUNT; i++) begin
      pt_vld[i] = 1'b0;
      pt_frm[i] = '0;
    end

    // directed: address extremes, hits, TLB fill, LRU eviction, table hit
    push_addr(16'h0000);
    push_addr(16'hFFFF);
    push_addr(16'h00FF);
    push_addr(16'hFF00);
    push_addr(16'h5AA5);
    push_addr(16'hA55A);
    for (int p = 1; p <= 14; p++) push_addr({p[PAGE_W-1:0], 8'($urandom)});
    push_addr(16'h0000);
    push_drain();

    n     = 0;
    swept = 1'b0;
    while (n < ADDR_BEATS) begin
      if (!swept && n >= 600) begin
        // every page once, so the free-frame pointer runs out
        for (int i = 0; i < PAGE_COUNT; i++) perm[i] = i;
        for (int i = PAGE_COUNT - 1; i > 0; i--) begin
          j       = $urandom_range(0, i);
          tmp     = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < PAGE_COUNT; i++) push_addr({perm[i][PAGE_W-1:0], 8'($urandom)});
        n     += PAGE_COUNT;
        swept  = 1'b1;
        push_drain();
      end
      mode = $urandom_range(0, 9);
      run  = $urandom_range(10, 40);
      if (mode < 6) begin
        // working set around the TLB size: hits and LRU churn
        k = $urandom_range(4, TLB_N + 8);
        ws.delete();
        for (int i = 0; i < k; i++) ws.push_back($urandom_range(0, PAGE_COUNT - 1));
        for (int i = 0; i < run; i++)
          push_addr({ws[$urandom_range(0, k - 1)][PAGE_W-1:0], 8'($urandom)});
      end else if (mode < 9) begin
        for (int i = 0; i < run; i++) push_addr(16'($urandom));
      end else begin
        pg = $urandom_range(0, PAGE_COUNT - 1);
        for (int i = 0; i < run; i++) push_addr({8'(pg + i), 8'($urandom)});
      end
      n += run;
      if ($urandom_range(0, 19) == 0) push_drain();
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (addr_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_xlat_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_xlat_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/tlb_lru_pkg.sv
design/tlb_lru_ram.sv
design/tlb_lru_ptab.sv
design/tlb_lru_cam.sv
design/tlb_lru_page_translation.sv
sim/tlb_lru_page_translation_tb.sv
